// ----- rtl/core/hrc_pkg.sv -----
// hrc_pkg: item types, constants and the hue profile function for the hls to rgb converter
// no dependencies; imported by hrc_chan, hls_to_rgb_converter and the tb
`default_nettype none

package hrc_pkg;

    // input item: hue in degrees, lightness and saturation with 256 as one
    typedef struct packed {
        logic [8:0] hue_deg;
        logic [8:0] lightness;
        logic [8:0] saturation;
    } t_hls_item;

    // result item: 8-bit channels
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_item;

    // load enables handed to the channel back end
    typedef struct packed {
        logic ld_num;
        logic ld_byte;
    } t_chan_ctl;

    localparam logic [8:0] ONE_Q8  = 9'd256;
    localparam logic [8:0] HALF_Q8 = 9'd128;
    localparam logic [7:0] FULL_SCALE = 8'd255;

    localparam logic signed [10:0] HUE_FULL   = 11'sd360;
    localparam logic signed [10:0] HUE_THIRD  = 11'sd120;
    localparam logic signed [10:0] SEG_RISE   = 11'sd60;
    localparam logic signed [10:0] SEG_TOP    = 11'sd180;
    localparam logic signed [10:0] SEG_FALL   = 11'sd240;
    localparam logic [5:0]         SEG_DEG    = 6'd60;

    // profile weight 0..60 of the upper level at a hue position, wrapped once
    function automatic logic [5:0] profile_k(input logic signed [10:0] pos);
        logic signed [10:0] h;
        logic signed [10:0] fall;
        logic [5:0]         k;
        h = pos;
        if (h > HUE_FULL) begin
            h = h - HUE_FULL;
        end
        if (h < 11'sd0) begin
            h = h + HUE_FULL;
        end
        fall = SEG_FALL - h;
        if (h < SEG_RISE) begin
            k = h[5:0];
        end else if (h < SEG_TOP) begin
            k = SEG_DEG;
        end else if (h < SEG_FALL) begin
            k = fall[5:0];
        end else begin
            k = 6'd0;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hrc_chan.sv -----
// hrc_chan: one color channel back end, level blend and 8-bit scaling over two stages
// depends on hrc_pkg for t_chan_ctl, SEG_DEG and FULL_SCALE
`default_nettype none

module hrc_chan
    import hrc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_chan_ctl   i_ctl,
    input  wire logic [16:0] i_lo,
    input  wire logic [16:0] i_diff,
    input  wire logic [5:0]  i_k,
    output logic [7:0]       o_byte
);

    logic [21:0] r_num;
    logic [21:0] n_num;
    logic [7:0]  r_byte;
    logic [7:0]  n_byte;
    logic [26:0] scaled;
    logic [8:0]  level;

    // blend numerator over 60*65536: lo*60 + (hi-lo)*k
    always_comb begin
        n_num = ({5'd0, i_lo} * {16'd0, SEG_DEG}) + ({5'd0, i_diff} * {16'd0, i_k});
    end

    // times 255/(60*65536) reduces to times 17 then shift by 18
    always_comb begin
        scaled = {5'd0, r_num} + {1'b0, r_num, 4'd0};
        level  = scaled[26:18];
        n_byte = (level > {1'b0, FULL_SCALE}) ? FULL_SCALE : level[7:0];
    end

    // stage registers, payload only
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_num) begin
            r_num <= n_num;
        end
        if (i_ctl.ld_byte) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

// ----- rtl/core/hls_to_rgb_converter.sv -----
// hls_to_rgb_converter: top level of the five-stage hls to rgb pipeline
// depends on hrc_pkg and hrc_chan
`default_nettype none

// Converts one pixel per clock, while no back pressure holds the pipeline, from
// hue (degrees), lightness and saturation (256 = 1.0, values above clamp to 1.0)
// to 8-bit red, green and blue. A new item can be accepted in every cycle in
// which o_in_ready is high; each item passes through the pipeline stages: hue
// profile weights, the lightness by saturation product, the upper and lower
// levels, the per-channel blend multiply, and the scaling to 8 bits into the
// output register. Each stage holds while the stage after it is full and
// stalled, so back pressure fills bubbles first and then reaches o_in_ready.
module hls_to_rgb_converter
    import hrc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_hls_item i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_rgb_item      o_out_data
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] stage_rdy;

    // stage 1: clamped inputs and profile weights (red, green, blue)
    logic [8:0]      r1_l, r1_s, n1_l, n1_s;
    logic [2:0][5:0] r1_k, n1_k;
    // stage 2: lightness and half level spread
    logic [8:0]      r2_l;
    logic [15:0]     r2_half, n2_half;
    logic [2:0][5:0] r2_k;
    // stage 3: lower level and spread
    logic [16:0]     r3_lo, r3_diff, n3_lo, n3_diff;
    logic [2:0][5:0] r3_k;

    logic signed [10:0] hue_s;
    logic [16:0]        prod;
    logic [16:0]        half_w;
    t_chan_ctl          chan_ctl;
    logic [2:0][7:0]    chan_byte;

    // ready chain from the output register back to the input
    always_comb begin
        stage_rdy[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            stage_rdy[i] = !r_vld[i] || stage_rdy[i+1];
        end
    end

    // valid bits move with the data
    always_comb begin
        for (int i = 0; i < STAGES; i++) begin
            if (stage_rdy[i]) begin
                n_vld[i] = (i == 0) ? i_in_valid : r_vld[(i == 0) ? 0 : i - 1];
            end else begin
                n_vld[i] = r_vld[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // stage 1 logic: clamp and hue positions at +120, 0 and -120 degrees
    always_comb begin
        n1_l  = (i_in_data.lightness  > ONE_Q8) ? ONE_Q8 : i_in_data.lightness;
        n1_s  = (i_in_data.saturation > ONE_Q8) ? ONE_Q8 : i_in_data.saturation;
        hue_s = $signed({2'b00, i_in_data.hue_deg});
        n1_k[2] = profile_k(hue_s + HUE_THIRD);
        n1_k[1] = profile_k(hue_s);
        n1_k[0] = profile_k(hue_s - HUE_THIRD);
    end

    // stage 2 logic: half spread is l*s below one half, s*(256-l) above
    always_comb begin
        prod = {8'd0, r1_l} * {8'd0, r1_s};
        if (r1_l <= HALF_Q8) begin
            half_w = prod;
        end else begin
            half_w = {r1_s, 8'd0} - prod;
        end
        n2_half = half_w[15:0];
    end

    // stage 3 logic: lower level 256l - half, spread hi - lo = 2*half
    always_comb begin
        n3_lo   = {r2_l, 8'd0} - {1'b0, r2_half};
        n3_diff = {r2_half, 1'b0};
    end

    // front stage registers, payload only
    always_ff @(posedge i_clk) begin
        if (stage_rdy[0]) begin
            r1_l <= n1_l;
            r1_s <= n1_s;
            r1_k <= n1_k;
        end
        if (stage_rdy[1]) begin
            r2_l    <= r1_l;
            r2_half <= n2_half;
            r2_k    <= r1_k;
        end
        if (stage_rdy[2]) begin
            r3_lo   <= n3_lo;
            r3_diff <= n3_diff;
            r3_k    <= r2_k;
        end
    end

    // channel back ends: blend and scaling stages
    assign chan_ctl.ld_num  = stage_rdy[3];
    assign chan_ctl.ld_byte = stage_rdy[4];

    for (genvar c = 0; c < 3; c++) begin : g_chan
        hrc_chan u_chan (
            .i_clk  (i_clk),
            .i_ctl  (chan_ctl),
            .i_lo   (r3_lo),
            .i_diff (r3_diff),
            .i_k    (r3_k[c]),
            .o_byte (chan_byte[c])
        );
    end

    assign o_in_ready       = stage_rdy[0];
    assign o_out_valid      = r_vld[STAGES-1];
    assign o_out_data.red   = chan_byte[2];
    assign o_out_data.green = chan_byte[1];
    assign o_out_data.blue  = chan_byte[0];

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// tb: self-checking testbench for hls_to_rgb_converter, directed table then random pixels
// depends on hrc_pkg and the hls_to_rgb_converter rtl; predicts rgb per item and scoreboards it
`timescale 1ns / 100ps

module tb;
    import hrc_pkg::*;

    localparam int NUM_RANDOM  = 1330;
    localparam int PHASE_ITEMS = NUM_RANDOM / 3;
    localparam int TAIL_CYCLES = 12;
    localparam int SHOW_LIMIT  = 10;

    // fixed-point scale of the hls math
    localparam longint unsigned Q8_ONE   = 256;
    localparam longint unsigned Q8_HALF  = 128;
    localparam longint unsigned BYTE_MAX = 255;
    localparam longint unsigned SEG_SPAN = 60;
    localparam longint unsigned LEVEL_DEN = 60 * 65536;
    localparam int HUE_WRAP  = 360;
    localparam int HUE_SHIFT = 120;
    localparam int HUE_RISE  = 60;
    localparam int HUE_TOP   = 180;
    localparam int HUE_FALL  = 240;

    typedef struct {
        t_hls_item px;
        bit        known;
        t_rgb_item rgb;
    } pixel_row_t;

    typedef struct {
        t_hls_item px;
        t_rgb_item rgb;
    } pending_rgb_t;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_hls_item i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_rgb_item o_out_data;

    pending_rgb_t rgb_pending[$];
    pixel_row_t   pixel_rows[$];
    int           mismatch_count = 0;
    int           send_idle_pct  = 38;
    int           recv_idle_pct  = 55;

    hls_to_rgb_converter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // numerator over LEVEL_DEN of one channel at a hue profile position
    function automatic longint unsigned hue_level_num(longint unsigned lo, longint unsigned hi,
                                                      int pos);
        int h;
        h = pos;
        if (h > HUE_WRAP) begin
            h = h - HUE_WRAP;
        end
        if (h < 0) begin
            h = h + HUE_WRAP;
        end
        if (h < HUE_RISE) begin
            return lo * SEG_SPAN + (hi - lo) * longint'(h);
        end else if (h < HUE_TOP) begin
            return hi * SEG_SPAN;
        end else if (h < HUE_FALL) begin
            return lo * SEG_SPAN + (hi - lo) * longint'(HUE_FALL - h);
        end
        return lo * SEG_SPAN;
    endfunction

    // scale a level to 8 bits: single truncation, then clamp
    function automatic logic [7:0] level_to_byte(longint unsigned num);
        longint unsigned v;
        v = (num * BYTE_MAX) / LEVEL_DEN;
        if (v > BYTE_MAX) begin
            v = BYTE_MAX;
        end
        return v[7:0];
    endfunction

    // expected rgb of one hls pixel
    function automatic t_rgb_item hls_pixel_to_rgb(t_hls_item px);
        longint unsigned l;
        longint unsigned s;
        longint unsigned hi;
        longint unsigned lo;
        int              h;
        t_rgb_item       rgb;
        h = int'(px.hue_deg);
        l = (px.lightness > Q8_ONE) ? Q8_ONE : longint'(px.lightness);
        s = (px.saturation > Q8_ONE) ? Q8_ONE : longint'(px.saturation);
        if (l <= Q8_HALF) begin
            hi = l * (Q8_ONE + s);
        end else begin
            hi = l * Q8_ONE + s * Q8_ONE - l * s;
        end
        lo = 2 * l * Q8_ONE - hi;
        if (s == 0) begin
            rgb.red   = level_to_byte(l * Q8_ONE * SEG_SPAN);
            rgb.green = rgb.red;
            rgb.blue  = rgb.red;
        end else begin
            rgb.red   = level_to_byte(hue_level_num(lo, hi, h + HUE_SHIFT));
            rgb.green = level_to_byte(hue_level_num(lo, hi, h));
            rgb.blue  = level_to_byte(hue_level_num(lo, hi, h - HUE_SHIFT));
        end
        return rgb;
    endfunction

    // random pixel: mostly in range, some corners, some with every bit free
    function automatic t_hls_item rand_hls();
        int unsigned hue_corner[12] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359};
        int unsigned lvl_corner[9]  = '{0, 1, 59, 60, 127, 128, 129, 255, 256};
        t_hls_item   px;
        case ($urandom_range(0, 9))
            0: begin
                px.hue_deg    = 9'($urandom_range(0, 511));
                px.lightness  = 9'($urandom_range(0, 511));
                px.saturation = 9'($urandom_range(0, 511));
            end
            1, 2: begin
                px.hue_deg    = 9'(hue_corner[$urandom_range(0, 11)]);
                px.lightness  = 9'(lvl_corner[$urandom_range(0, 8)]);
                px.saturation = 9'(lvl_corner[$urandom_range(0, 8)]);
            end
            default: begin
                px.hue_deg    = 9'($urandom_range(0, 359));
                px.lightness  = 9'($urandom_range(0, 256));
                px.saturation = 9'($urandom_range(0, 256));
            end
        endcase
        return px;
    endfunction

    task automatic add_row(int h, int l, int s, bit known, int r, int g, int b);
        pixel_row_t row;
        row.px.hue_deg    = 9'(h);
        row.px.lightness  = 9'(l);
        row.px.saturation = 9'(s);
        row.known         = known;
        row.rgb.red       = 8'(r);
        row.rgb.green     = 8'(g);
        row.rgb.blue      = 8'(b);
        pixel_rows.push_back(row);
    endtask

    // offer one item, wait for it to be taken, then queue what it should produce
    task automatic send_pixel(t_hls_item px, bit known, t_rgb_item rgb);
        pending_rgb_t want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        want.px  = px;
        want.rgb = known ? rgb : hls_pixel_to_rgb(px);
        rgb_pending.push_back(want);
    endtask

    // stop offering items until every queued result has come out
    task automatic drain_pending();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (rgb_pending.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // result scoreboard and receiver back pressure
    always @(posedge i_clk) begin : rgb_check
        pending_rgb_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rgb_pending.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= SHOW_LIMIT) begin
                    $display("tb: unexpected item rgb %0d/%0d/%0d", o_out_data.red,
                             o_out_data.green, o_out_data.blue);
                end
            end else begin
                want = rgb_pending.pop_front();
                if (o_out_data.red !== want.rgb.red || o_out_data.green !== want.rgb.green
                        || o_out_data.blue !== want.rgb.blue) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= SHOW_LIMIT) begin
                        $display("tb: hls %0d/%0d/%0d expected rgb %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.px.hue_deg, want.px.lightness, want.px.saturation,
                                 want.rgb.red, want.rgb.green, want.rgb.blue,
                                 o_out_data.red, o_out_data.green, o_out_data.blue);
                    end
                end
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // stimulus
    initial begin : stimulus
        t_rgb_item none;
        none = '0;

        // directed rows: grey, pure primaries and secondaries, white, black, clamping
        add_row(0, 0, 0, 1, 0, 0, 0);
        add_row(0, 256, 0, 1, 255, 255, 255);
        add_row(0, 128, 0, 1, 127, 127, 127);
        add_row(0, 128, 256, 1, 255, 0, 0);
        add_row(120, 128, 256, 1, 0, 255, 0);
        add_row(240, 128, 256, 1, 0, 0, 255);
        add_row(60, 128, 256, 1, 255, 255, 0);
        add_row(180, 128, 256, 1, 0, 255, 255);
        add_row(300, 128, 256, 1, 255, 0, 255);
        add_row(359, 256, 256, 1, 255, 255, 255);
        add_row(200, 0, 256, 1, 0, 0, 0);
        add_row(511, 511, 511, 1, 255, 255, 255);
        add_row(511, 128, 511, 0, 0, 0, 0);
        add_row(360, 128, 256, 0, 0, 0, 0);
        add_row(30, 64, 128, 0, 0, 0, 0);
        add_row(359, 200, 100, 0, 0, 0, 0);
        add_row(1, 129, 255, 0, 0, 0, 0);
        add_row(239, 127, 1, 0, 0, 0, 0);
        add_row(480, 300, 0, 0, 0, 0, 0);
        add_row(0, 1, 256, 0, 0, 0, 0);
        add_row(90, 255, 256, 0, 0, 0, 0);
        add_row(256, 384, 200, 0, 0, 0, 0);
        add_row(59, 129, 129, 0, 0, 0, 0);
        add_row(419, 257, 300, 0, 0, 0, 0);

        // reset
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (pixel_rows[i]) begin
            send_pixel(pixel_rows[i].px, pixel_rows[i].known, pixel_rows[i].rgb);
        end
        drain_pending();

        // random pixels, three idling phases
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == PHASE_ITEMS) begin
                drain_pending();
                send_idle_pct = 55;
                recv_idle_pct = 38;
            end else if (n == 2 * PHASE_ITEMS) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_pixel(rand_hls(), 1'b0, none);
        end

        // wait out the pipeline, then report
        drain_pending();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
